// ===== src/srlc_pkg.sv =====
// ----------------------------------------------------------------------------
// srlc_pkg: shared types and constants for the selective-repeat link controller
// Sequence and window sizes, action and command codes, sequencer states.
// ----------------------------------------------------------------------------
package srlc_pkg;

  localparam int SEQ_BITS    = 4;
  localparam int WINDOW      = 8;
  localparam int SLOT_BITS   = $clog2(WINDOW);
  localparam int CNT_BITS    = $clog2(WINDOW + 1);
  localparam int TICK_BITS   = 16;
  localparam int MAX_RESULTS = 20;
  localparam int EMIT_BITS   = $clog2(MAX_RESULTS);

  localparam int IN_DATA_BITS  = 16;
  localparam int OUT_DATA_BITS = 32;

  typedef logic [SEQ_BITS-1:0]  seq_t;
  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [TICK_BITS-1:0] ticks_t;

  localparam seq_t   SEQ_ONE     = seq_t'(1);
  localparam seq_t   SEQ_MASK    = '1;
  localparam seq_t   RWE_RESET   = seq_t'(WINDOW % (2 ** SEQ_BITS));
  localparam cnt_t   WINDOW_CNT  = cnt_t'(WINDOW);
  localparam ticks_t DATA_TO_RST = ticks_t'(3000);
  localparam ticks_t ACK_TO_RST  = ticks_t'(240);

  // register indexes
  localparam logic REG_DATA_TIMEOUT = 1'b0;
  localparam logic REG_ACK_TIMEOUT  = 1'b1;

  typedef enum logic [2:0] {
    CMD_PKT_READY  = 3'd0,
    CMD_PHY_READY  = 3'd1,
    CMD_FRAME_RX   = 3'd2,
    CMD_DATA_TMO   = 3'd3,
    CMD_ACK_TMO    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NAK  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ACT_SEND_DATA = 3'd0,
    ACT_SEND_ACK  = 3'd1,
    ACT_SEND_NAK  = 3'd2,
    ACT_DELIVER   = 3'd3,
    ACT_STOP_TMR  = 3'd4,
    ACT_START_ACK = 3'd5,
    ACT_NET       = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ARRIVE,
    ST_DELIVER,
    ST_NAKRX,
    ST_STOP,
    ST_NET
  } state_t;

  // operands of the shared window compare
  typedef struct packed {
    seq_t lo;
    seq_t x;
    seq_t hi;
  } win_req_t;

endpackage

// ===== src/selective_repeat_link_controller.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_link_controller: selective-repeat ARQ event sequencer
// Takes one link event per input beat and emits the resulting action beats.
// ----------------------------------------------------------------------------
// One event is taken per input beat; s_tready drops until the event's final
// action (the network enable/disable beat, m_tlast high) has been loaded into
// the output register. The sequencer makes one step per cycle while the
// output register is free (back-pressure on m_tready holds it) and emits at
// most one action per step. Every window check (receive window, NAK
// retransmit, cumulative ack) goes through one shared modular compare
// unit, and delivery and ack release run as loops of that sequencer, one slot
// per step. Configuration writes are taken at any time and should be made
// while no event is in progress.
module selective_repeat_link_controller (
  input  logic                                 clk,
  input  logic                                 rst,
  // config port
  input  logic                                 cfg_wr_en,
  input  logic                                 cfg_addr,
  input  logic [srlc_pkg::TICK_BITS-1:0]       cfg_wdata,
  // event input
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [srlc_pkg::IN_DATA_BITS-1:0]    s_tdata,  // frame_good, frame_kind[1:0],
                                                          // frame_seq[3:0], ack_num[3:0]
  input  logic [2:0]                           s_tuser,  // command
  // action output
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [srlc_pkg::OUT_DATA_BITS-1:0]   m_tdata,  // frame_seq_out[3:0], ack_out[3:0],
                                                          // buffer_slot[2:0], timer_ticks[15:0],
                                                          // network_enable
  output logic [2:0]                           m_tuser,  // action
  output logic                                 m_tlast   // last
);
  import srlc_pkg::*;

  // config
  ticks_t data_timeout_ticks;
  ticks_t ack_timeout_ticks;

  // latched event
  logic [2:0] cmd;
  logic       frame_good;
  logic [1:0] frame_kind;
  seq_t       frame_seq;
  seq_t       rx_ack;

  // protocol state
  seq_t        ack_expected_seq, ack_expected_seq_next;
  seq_t        next_send_seq, next_send_seq_next;
  seq_t        frame_expected_seq, frame_expected_seq_next;
  seq_t        receive_window_end, receive_window_end_next;
  cnt_t        in_flight_count, in_flight_count_next;
  logic        nak_allowed, nak_allowed_next;
  logic        physical_ready, physical_ready_next;
  logic [WINDOW-1:0] slot_arrived, slot_arrived_next;
  logic        delivered, delivered_next;

  state_t state, state_next;
  logic [EMIT_BITS-1:0] emit_cnt;

  // emission of the current step
  logic    emit_vld;
  action_e emit_act;
  seq_t    emit_seq;
  seq_t    emit_ack;
  slot_t   emit_slot;
  ticks_t  emit_ticks;
  logic    emit_en;
  logic    emit_keep;

  logic     in_accept;
  logic     out_free;
  logic     step;
  win_req_t win_req;
  logic     win_hit;
  seq_t     ack_field;
  seq_t     nak_seq;

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign step      = (state != ST_IDLE) && out_free;
  assign ack_field = frame_expected_seq + SEQ_MASK;
  assign nak_seq   = rx_ack + SEQ_ONE;

  srlc_wincmp u_wincmp (
    .req (win_req),
    .hit (win_hit)
  );

  always_comb begin
    case (state)
      ST_ARRIVE: win_req = '{lo: frame_expected_seq, x: frame_seq, hi: receive_window_end};
      ST_NAKRX:  win_req = '{lo: ack_expected_seq, x: nak_seq, hi: next_send_seq};
      default:   win_req = '{lo: ack_expected_seq, x: rx_ack, hi: next_send_seq};
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_START;
      end
      ST_START: begin
        if (step) begin
          if (cmd == CMD_FRAME_RX && frame_good) begin
            if (frame_kind == KIND_DATA)     state_next = ST_ARRIVE;
            else if (frame_kind == KIND_NAK) state_next = ST_NAKRX;
            else                             state_next = ST_STOP;
          end else begin
            state_next = ST_NET;
          end
        end
      end
      ST_ARRIVE: begin
        if (step) begin
          if (win_hit && !slot_arrived[slot_t'(frame_seq)]) state_next = ST_DELIVER;
          else                                              state_next = ST_STOP;
        end
      end
      ST_DELIVER: begin
        if (step && !slot_arrived[slot_t'(frame_expected_seq)]) state_next = ST_STOP;
      end
      ST_NAKRX: begin
        if (step) state_next = ST_STOP;
      end
      ST_STOP: begin
        if (step && !win_hit) state_next = ST_NET;
      end
      ST_NET: begin
        if (step) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // emitted action and protocol state updates
  always_comb begin
    ack_expected_seq_next   = ack_expected_seq;
    next_send_seq_next      = next_send_seq;
    frame_expected_seq_next = frame_expected_seq;
    receive_window_end_next = receive_window_end;
    in_flight_count_next    = in_flight_count;
    nak_allowed_next        = nak_allowed;
    physical_ready_next     = physical_ready;
    slot_arrived_next       = slot_arrived;
    delivered_next          = delivered;
    emit_vld   = 1'b0;
    emit_act   = ACT_NET;
    emit_seq   = '0;
    emit_ack   = '0;
    emit_slot  = '0;
    emit_ticks = '0;
    emit_en    = 1'b0;
    if (step) begin
      case (state)
        ST_START: begin
          case (cmd)
            CMD_PKT_READY: begin
              if (in_flight_count < WINDOW_CNT) begin
                in_flight_count_next = in_flight_count + cnt_t'(1);
                emit_vld   = 1'b1;
                emit_act   = ACT_SEND_DATA;
                emit_seq   = next_send_seq;
                emit_ack   = ack_field;
                emit_slot  = slot_t'(next_send_seq);
                emit_ticks = data_timeout_ticks;
                physical_ready_next = 1'b0;
                next_send_seq_next  = next_send_seq + SEQ_ONE;
              end
            end
            CMD_PHY_READY: physical_ready_next = 1'b1;
            CMD_FRAME_RX: begin
              if (!frame_good || frame_kind == KIND_DATA) begin
                if (nak_allowed && (!frame_good || frame_seq != frame_expected_seq)) begin
                  emit_vld = 1'b1;
                  emit_act = ACT_SEND_NAK;
                  emit_ack = ack_field;
                  nak_allowed_next    = 1'b0;
                  physical_ready_next = 1'b0;
                end else if (frame_good) begin
                  emit_vld   = 1'b1;
                  emit_act   = ACT_START_ACK;
                  emit_ticks = ack_timeout_ticks;
                end
              end
            end
            CMD_DATA_TMO: begin
              emit_vld   = 1'b1;
              emit_act   = ACT_SEND_DATA;
              emit_seq   = ack_expected_seq;
              emit_ack   = ack_field;
              emit_slot  = slot_t'(ack_expected_seq);
              emit_ticks = data_timeout_ticks;
              physical_ready_next = 1'b0;
            end
            CMD_ACK_TMO: begin
              emit_vld = 1'b1;
              emit_act = ACT_SEND_ACK;
              emit_ack = ack_field;
              physical_ready_next = 1'b0;
            end
            default: ;
          endcase
        end
        ST_ARRIVE: begin
          delivered_next = 1'b0;
          if (win_hit && !slot_arrived[slot_t'(frame_seq)])
            slot_arrived_next[slot_t'(frame_seq)] = 1'b1;
        end
        ST_DELIVER: begin
          if (slot_arrived[slot_t'(frame_expected_seq)]) begin
            emit_vld  = 1'b1;
            emit_act  = ACT_DELIVER;
            emit_seq  = frame_expected_seq;
            emit_slot = slot_t'(frame_expected_seq);
            nak_allowed_next = 1'b1;
            slot_arrived_next[slot_t'(frame_expected_seq)] = 1'b0;
            frame_expected_seq_next = frame_expected_seq + SEQ_ONE;
            receive_window_end_next = receive_window_end + SEQ_ONE;
            delivered_next = 1'b1;
          end else if (delivered) begin
            // one timer restart closes the delivery run
            emit_vld   = 1'b1;
            emit_act   = ACT_START_ACK;
            emit_ticks = ack_timeout_ticks;
          end
        end
        ST_NAKRX: begin
          if (win_hit) begin
            emit_vld   = 1'b1;
            emit_act   = ACT_SEND_DATA;
            emit_seq   = nak_seq;
            emit_ack   = ack_field;
            emit_slot  = slot_t'(nak_seq);
            emit_ticks = data_timeout_ticks;
            physical_ready_next = 1'b0;
          end
        end
        ST_STOP: begin
          if (win_hit) begin
            if (in_flight_count != '0) in_flight_count_next = in_flight_count - cnt_t'(1);
            emit_vld  = 1'b1;
            emit_act  = ACT_STOP_TMR;
            emit_seq  = ack_expected_seq;
            emit_slot = slot_t'(ack_expected_seq);
            ack_expected_seq_next = ack_expected_seq + SEQ_ONE;
          end
        end
        ST_NET: begin
          emit_vld = 1'b1;
          emit_act = ACT_NET;
          emit_en  = (in_flight_count < WINDOW_CNT) && physical_ready;
        end
        default: ;
      endcase
    end
  end

  // beyond the result limit only the network decision still goes out
  assign emit_keep = (emit_act == ACT_NET) ||
                     (emit_cnt < EMIT_BITS'(MAX_RESULTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      data_timeout_ticks <= DATA_TO_RST;
      ack_timeout_ticks  <= ACK_TO_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_DATA_TIMEOUT: data_timeout_ticks <= cfg_wdata;
        REG_ACK_TIMEOUT:  ack_timeout_ticks  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd        <= s_tuser;
      frame_good <= s_tdata[0];
      frame_kind <= s_tdata[2:1];
      frame_seq  <= s_tdata[6:3];
      rx_ack     <= s_tdata[10:7];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      ack_expected_seq   <= '0;
      next_send_seq      <= '0;
      frame_expected_seq <= '0;
      receive_window_end <= RWE_RESET;
      in_flight_count    <= '0;
      nak_allowed        <= 1'b1;
      physical_ready     <= 1'b0;
      slot_arrived       <= '0;
      delivered          <= 1'b0;
      emit_cnt           <= '0;
    end else begin
      state              <= state_next;
      ack_expected_seq   <= ack_expected_seq_next;
      next_send_seq      <= next_send_seq_next;
      frame_expected_seq <= frame_expected_seq_next;
      receive_window_end <= receive_window_end_next;
      in_flight_count    <= in_flight_count_next;
      nak_allowed        <= nak_allowed_next;
      physical_ready     <= physical_ready_next;
      slot_arrived       <= slot_arrived_next;
      delivered          <= delivered_next;
      if (in_accept) begin
        emit_cnt <= '0;
      end else if (emit_vld && emit_act != ACT_NET && emit_keep) begin
        emit_cnt <= emit_cnt + EMIT_BITS'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_vld && emit_keep) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_vld && emit_keep) begin
      m_tdata <= {4'b0000, emit_en, emit_ticks, emit_slot, emit_ack, emit_seq};
      m_tuser <= emit_act;
      m_tlast <= (emit_act == ACT_NET);
    end
  end

  // frames outstanding always match the sender window span
  a_inflight_span: assert property (@(posedge clk) disable iff (rst)
    cnt_t'(seq_t'(next_send_seq - ack_expected_seq)) == in_flight_count)
    else $error("in-flight count out of step with sender window");

  a_inflight_max: assert property (@(posedge clk) disable iff (rst)
    in_flight_count <= WINDOW_CNT)
    else $error("in-flight count above window");

  a_last_is_net: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == ACT_NET)))
    else $error("last beat is not the network decision");

  a_ready_after_net: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NET && step) |=> (s_tready && m_tvalid && m_tlast))
    else $error("event did not close with the network decision");

endmodule

// ===== src/srlc_wincmp.sv =====
// ----------------------------------------------------------------------------
// srlc_wincmp: modular window compare
// True when x lies in [lo, hi) on the sequence-number circle.
// ----------------------------------------------------------------------------
module srlc_wincmp (
  input  srlc_pkg::win_req_t req,
  output logic               hit
);
  import srlc_pkg::*;

  seq_t dist_x;
  seq_t dist_hi;

  assign dist_x  = req.x  - req.lo;
  assign dist_hi = req.hi - req.lo;
  assign hit     = dist_x < dist_hi;

endmodule

// ===== sim/tb_selective_repeat_link_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_selective_repeat_link_controller: event-level check of the ARQ sequencer
// Link events go in one beat at a time and the action beats that come out
// are compared field by field against a behavioral predictor of both
// windows. Directed events come first, then random link traffic under
// several timeout settings, with random gaps on both stream interfaces.
// ----------------------------------------------------------------------------
module tb_selective_repeat_link_controller;
  import srlc_pkg::*;

  localparam int QUIET_LIMIT = 1500;

  typedef struct packed {
    logic [2:0] cmd;
    logic       good;
    logic [1:0] kind;
    seq_t       seq;
    seq_t       ack;
  } link_event_t;

  typedef struct packed {
    action_e act;
    seq_t    seq;
    seq_t    ack;
    slot_t   slot;
    ticks_t  ticks;
    logic    en;
    logic    last;
  } link_action_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic                     cfg_addr = 1'b0;
  logic [TICK_BITS-1:0]     cfg_wdata = '0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;   // frame_good, frame_kind[1:0],
                                            // frame_seq[3:0], ack_num[3:0]
  logic [2:0]               s_tuser = '0;   // command
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;        // frame_seq_out[3:0], ack_out[3:0],
                                            // buffer_slot[2:0], timer_ticks[15:0],
                                            // network_enable
  logic [2:0]               m_tuser;        // action
  logic                     m_tlast;

  selective_repeat_link_controller u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // link state as the predictor sees it
  ticks_t            cfg_data_ticks;
  ticks_t            cfg_ack_ticks;
  seq_t              rx_ack_exp;
  seq_t              tx_next;
  seq_t              rx_frame_exp;
  seq_t              rx_win_end;
  int                tx_outstanding;
  bit                nak_ok;
  bit                phy_rdy;
  bit [WINDOW-1:0]   rx_arrived;

  link_action_t      burst[MAX_RESULTS];
  int                n_burst;
  link_action_t      pending_actions[$];
  link_action_t      seen_beat;
  link_action_t      want_beat;

  bit tx_idle_en;
  bit rx_stall_en;
  int rx_hold;
  int quiet_cycles;
  int n_errors;
  int n_events;
  int n_random;
  int n_beats;
  int n_deliveries;
  int n_data_sends;
  int n_naks;
  int n_stops;
  int n_window_full;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic bit seq_between(seq_t lo, seq_t x, seq_t hi);
    seq_t a;
    seq_t b;
    a = x - lo;
    b = hi - lo;
    return a < b;
  endfunction

  function automatic void push_action(action_e a, seq_t sq, seq_t ak, slot_t sl,
                                      ticks_t tk, logic en);
    if (n_burst >= MAX_RESULTS) return;
    burst[n_burst].act   = a;
    burst[n_burst].seq   = sq;
    burst[n_burst].ack   = ak;
    burst[n_burst].slot  = sl;
    burst[n_burst].ticks = tk;
    burst[n_burst].en    = en;
    burst[n_burst].last  = 1'b0;
    n_burst++;
  endfunction

  // any frame send carries the cumulative ack and drops physical ready
  function automatic void tx_frame(action_e kind, seq_t sq);
    seq_t ak;
    ak = rx_frame_exp + SEQ_MASK;
    if (kind == ACT_SEND_DATA) begin
      push_action(ACT_SEND_DATA, sq, ak, slot_t'(sq), cfg_data_ticks, 1'b0);
      n_data_sends++;
    end else begin
      push_action(kind, '0, ak, '0, '0, 1'b0);
      if (kind == ACT_SEND_NAK) begin
        nak_ok = 1'b0;
        n_naks++;
      end
    end
    phy_rdy = 1'b0;
  endfunction

  task automatic predict_actions(link_event_t ev);
    seq_t nxt;
    bit   delivered;
    int   guard;
    int   i;
    n_burst = 0;
    case (ev.cmd)
      CMD_PKT_READY: begin
        if (tx_outstanding < WINDOW) begin
          tx_outstanding++;
          tx_frame(ACT_SEND_DATA, tx_next);
          tx_next++;
        end else begin
          n_window_full++;
        end
      end
      CMD_PHY_READY: phy_rdy = 1'b1;
      CMD_FRAME_RX: begin
        if (!ev.good) begin
          if (nak_ok) tx_frame(ACT_SEND_NAK, '0);
        end else begin
          if (ev.kind == KIND_DATA) begin
            if (ev.seq != rx_frame_exp && nak_ok) tx_frame(ACT_SEND_NAK, '0);
            else push_action(ACT_START_ACK, '0, '0, '0, cfg_ack_ticks, 1'b0);
            if (seq_between(rx_frame_exp, ev.seq, rx_win_end) &&
                !rx_arrived[slot_t'(ev.seq)]) begin
              delivered = 1'b0;
              rx_arrived[slot_t'(ev.seq)] = 1'b1;
              for (guard = 0; guard < WINDOW && rx_arrived[slot_t'(rx_frame_exp)];
                   guard++) begin
                push_action(ACT_DELIVER, rx_frame_exp, '0, slot_t'(rx_frame_exp), '0, 1'b0);
                nak_ok = 1'b1;
                rx_arrived[slot_t'(rx_frame_exp)] = 1'b0;
                rx_frame_exp++;
                rx_win_end++;
                delivered = 1'b1;
                n_deliveries++;
              end
              // one timer restart covers the whole run
              if (delivered) push_action(ACT_START_ACK, '0, '0, '0, cfg_ack_ticks, 1'b0);
            end
          end
          nxt = ev.ack + SEQ_ONE;
          if (ev.kind == KIND_NAK && seq_between(rx_ack_exp, nxt, tx_next))
            tx_frame(ACT_SEND_DATA, nxt);
          // kind 3 falls through here like a plain ack
          for (guard = 0; guard < (1 << SEQ_BITS) && seq_between(rx_ack_exp, ev.ack, tx_next);
               guard++) begin
            if (tx_outstanding > 0) tx_outstanding--;
            push_action(ACT_STOP_TMR, rx_ack_exp, '0, slot_t'(rx_ack_exp), '0, 1'b0);
            rx_ack_exp++;
            n_stops++;
          end
        end
      end
      CMD_DATA_TMO: tx_frame(ACT_SEND_DATA, rx_ack_exp);
      CMD_ACK_TMO:  tx_frame(ACT_SEND_ACK, '0);
      default: ;
    endcase
    if (n_burst >= MAX_RESULTS) n_burst = MAX_RESULTS - 1;
    push_action(ACT_NET, '0, '0, '0, '0, (tx_outstanding < WINDOW) && phy_rdy);
    burst[n_burst-1].last = 1'b1;
    for (i = 0; i < n_burst; i++) pending_actions.push_back(burst[i]);
  endtask

  function automatic link_event_t mk_event(logic [2:0] cmd, logic good, logic [1:0] kind,
                                           seq_t sq, seq_t ak);
    link_event_t ev;
    ev.cmd  = cmd;
    ev.good = good;
    ev.kind = kind;
    ev.seq  = sq;
    ev.ack  = ak;
    return ev;
  endfunction

  // mostly plausible traffic around both window edges, some noise
  function automatic link_event_t pick_random_event();
    link_event_t ev;
    int r;
    int k;
    ev.good = 1'(($urandom));
    ev.kind = 2'($urandom);
    ev.seq  = seq_t'($urandom);
    ev.ack  = seq_t'($urandom);
    r = $urandom_range(0, 99);
    if (r < 16) begin
      ev.cmd = CMD_PKT_READY;
    end else if (r < 30) begin
      ev.cmd = CMD_PHY_READY;
    end else if (r < 80) begin
      ev.cmd  = CMD_FRAME_RX;
      ev.good = ($urandom_range(0, 99) < 90);
      k = $urandom_range(0, 99);
      if (k < 50)      ev.kind = KIND_DATA;
      else if (k < 72) ev.kind = KIND_ACK;
      else if (k < 94) ev.kind = KIND_NAK;
      else             ev.kind = 2'd3;
      if ($urandom_range(0, 99) < 80)
        ev.seq = seq_t'(rx_frame_exp + $urandom_range(0, 9));
      if ($urandom_range(0, 99) < 80)
        ev.ack = seq_t'(rx_ack_exp + SEQ_MASK + $urandom_range(0, tx_outstanding));
    end else if (r < 88) begin
      ev.cmd = CMD_DATA_TMO;
    end else if (r < 96) begin
      ev.cmd = CMD_ACK_TMO;
    end else begin
      ev.cmd = 3'($urandom_range(5, 7));
    end
    return ev;
  endfunction

  task automatic send_event(link_event_t ev);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 99) < 40) gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_BITS'({ev.ack, ev.seq, ev.kind, ev.good});
    s_tuser  <= ev.cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_actions(ev);
    n_events++;
  endtask

  task automatic drain_actions();
    s_tvalid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, ticks_t val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_DATA_TIMEOUT) cfg_data_ticks = val;
    else cfg_ack_ticks = val;
  endtask

  task automatic test_reset_defaults();
    send_event(mk_event(3'd5, 1'b1, 2'd3, 4'd15, 4'd15));
    send_event(mk_event(3'd6, 1'b0, 2'd0, 4'd0, 4'd0));
    send_event(mk_event(3'd7, 1'b1, 2'd1, 4'd5, 4'd10));
    send_event(mk_event(CMD_PHY_READY, 1'b0, 2'd0, 4'd0, 4'd0));
    send_event(mk_event(CMD_ACK_TMO, 1'b0, 2'd0, 4'd0, 4'd0));
    // nothing in flight, still retransmits the oldest slot
    send_event(mk_event(CMD_DATA_TMO, 1'b0, 2'd0, 4'd0, 4'd0));
  endtask

  task automatic test_window_full();
    int i;
    drain_actions();
    write_reg(REG_DATA_TIMEOUT, 16'hFFFF);
    write_reg(REG_ACK_TIMEOUT, 16'd1);
    send_event(mk_event(CMD_PHY_READY, 1'b0, 2'd0, 4'd0, 4'd0));
    for (i = 0; i < WINDOW + 1; i++)
      send_event(mk_event(CMD_PKT_READY, 1'b0, 2'd0, 4'd0, 4'd0));
    send_event(mk_event(CMD_PHY_READY, 1'b0, 2'd0, 4'd0, 4'd0));
  endtask

  task automatic test_receive_paths();
    drain_actions();
    write_reg(REG_DATA_TIMEOUT, 16'd1);
    write_reg(REG_ACK_TIMEOUT, 16'hFFFF);
    send_event(mk_event(CMD_FRAME_RX, 1'b0, KIND_DATA, 4'd0, 4'd0));
    send_event(mk_event(CMD_FRAME_RX, 1'b0, KIND_ACK, 4'd3, 4'd3));
    // out of order arrivals, then the gap fills and a run is delivered
    send_event(mk_event(CMD_FRAME_RX, 1'b1, KIND_DATA, 4'd2, 4'd15));
    send_event(mk_event(CMD_FRAME_RX, 1'b1, KIND_DATA, 4'd1, 4'd15));
    send_event(mk_event(CMD_FRAME_RX, 1'b1, KIND_DATA, 4'd0, 4'd0));
    send_event(mk_event(CMD_FRAME_RX, 1'b1, KIND_NAK, 4'd9, 4'd2));
    send_event(mk_event(CMD_FRAME_RX, 1'b1, 2'd3, 4'd12, 4'd7));
    send_event(mk_event(CMD_FRAME_RX, 1'b1, KIND_DATA, 4'd15, 4'd10));
    send_event(mk_event(CMD_FRAME_RX, 1'b1, KIND_DATA, 4'd3, 4'd15));
  endtask

  task automatic test_random_traffic(int n_items, ticks_t data_tk, ticks_t ack_tk,
                                     bit tx_idle, bit rx_idle, bit pause_mid);
    int i;
    drain_actions();
    write_reg(REG_DATA_TIMEOUT, data_tk);
    write_reg(REG_ACK_TIMEOUT, ack_tk);
    tx_idle_en  = tx_idle;
    rx_stall_en = rx_idle;
    for (i = 0; i < n_items; i++) begin
      if (pause_mid && i == n_items / 2) drain_actions();
      send_event(pick_random_event());
      n_random++;
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_beat.act   = action_e'(m_tuser);
      seen_beat.seq   = m_tdata[3:0];
      seen_beat.ack   = m_tdata[7:4];
      seen_beat.slot  = m_tdata[10:8];
      seen_beat.ticks = m_tdata[26:11];
      seen_beat.en    = m_tdata[27];
      seen_beat.last  = m_tlast;
      n_beats++;
      if (pending_actions.size() == 0) begin
        $display("%0t: unexpected action beat, expected none, got action %0d seq %0d",
                 $time, seen_beat.act, seen_beat.seq);
        n_errors++;
      end else begin
        want_beat = pending_actions.pop_front();
        check_field("action", want_beat.act, seen_beat.act);
        check_field("frame_seq_out", want_beat.seq, seen_beat.seq);
        check_field("ack_out", want_beat.ack, seen_beat.ack);
        check_field("buffer_slot", want_beat.slot, seen_beat.slot);
        check_field("timer_ticks", want_beat.ticks, seen_beat.ticks);
        check_field("network_enable", want_beat.en, seen_beat.en);
        check_field("last", want_beat.last, seen_beat.last);
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_tready <= 1'b1;
      if (rx_stall_en && $urandom_range(0, 99) < 25) rx_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d actions outstanding",
                 $time, QUIET_LIMIT, pending_actions.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    cfg_data_ticks = DATA_TO_RST;
    cfg_ack_ticks  = ACK_TO_RST;
    rx_ack_exp     = '0;
    tx_next        = '0;
    rx_frame_exp   = '0;
    rx_win_end     = RWE_RESET;
    tx_outstanding = 0;
    nak_ok         = 1'b1;
    phy_rdy        = 1'b0;
    rx_arrived     = '0;
    tx_idle_en     = 1'b0;
    rx_stall_en    = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_window_full();
    test_receive_paths();
    test_random_traffic(100, ticks_t'($urandom_range(1, 65535)),
                        ticks_t'($urandom_range(1, 65535)), 1'b0, 1'b0, 1'b0);
    test_random_traffic(115, 16'd1, 16'hFFFF, 1'b1, 1'b0, 1'b1);
    test_random_traffic(115, 16'hFFFF, 16'd1, 1'b0, 1'b1, 1'b0);
    test_random_traffic(120, ticks_t'($urandom_range(1, 65535)),
                        ticks_t'($urandom_range(1, 65535)), 1'b1, 1'b1, 1'b1);
    drain_actions();

    $display("Run: %0d events (%0d random), %0d action beats checked, 4 timeout settings",
             n_events, n_random, n_beats);
    $display("Seen: %0d deliveries, %0d data sends, %0d NAKs, %0d timer stops, %0d full-window",
             n_deliveries, n_data_sends, n_naks, n_stops, n_window_full);
    if (n_errors == 0 && pending_actions.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
